@@ design/spt_pkg.sv @@
package spt_pkg;

   // access address width and stride width
   localparam int ADDR_W   = 64;
   localparam int STRIDE_W = 32;

   // index reduction works on the instruction address a few bits per cycle
   localparam int DIGIT_BITS  = 4;
   localparam int DIGIT_COUNT = ADDR_W / DIGIT_BITS;

   // entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // confidence state of one table entry
   typedef enum logic [1:0] {
      CONF_INIT      = 2'd0,
      CONF_STEADY    = 2'd1,
      CONF_TRANSIENT = 2'd2,
      CONF_NOPRED    = 2'd3
   } conf_type;

   // back end sequencer states
   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_LOOKUP,
      BK_RESOLVE
   } back_state_type;

   // one memory access as it travels from front to back
   typedef struct packed {
      logic [ADDR_W-1:0] pc;
      logic [ADDR_W-1:0] addr;
   } item_type;

   // one prediction table entry
   typedef struct packed {
      logic [ADDR_W-1:0]   tag;
      logic [ADDR_W-1:0]   last_addr;
      logic [STRIDE_W-1:0] stride;
      conf_type            conf;
   } entry_type;

   // sign extend a stride to address width
   function automatic logic [ADDR_W-1:0] sext_stride(input logic [STRIDE_W-1:0] s);
      return {{(ADDR_W - STRIDE_W){s[STRIDE_W-1]}}, s};
   endfunction

   // confidence step on a hit
   function automatic conf_type next_conf(input conf_type st, input logic ok);
      conf_type ns;
      ns = CONF_NOPRED;
      if (ok) begin
         ns = (st == CONF_NOPRED) ? CONF_TRANSIENT : CONF_STEADY;
      end else begin
         case (st)
            CONF_INIT:   ns = CONF_TRANSIENT;
            CONF_STEADY: ns = CONF_INIT;
            default:     ns = CONF_NOPRED;
         endcase
      end
      return ns;
   endfunction

endpackage

@@ design/spt_ram.sv @@
module spt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/spt_front.sv @@
module spt_front import spt_pkg::*; #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ADDR_W-1:0]                req_access_pc,
   input  logic [ADDR_W-1:0]                req_access_address,
   input  logic                             clearing,
   output logic                             q_valid,
   output item_type                         q_item,
   output logic [$clog2(TABLE_ENTRIES)-1:0] q_idx,
   input  logic                             q_pop
);

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int CNT_W  = $clog2(DIGIT_COUNT);
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam bit IS_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
   localparam logic [IDX_W:0]  MODULUS   = (IDX_W + 1)'(TABLE_ENTRIES);
   localparam logic [CNT_W-1:0] LAST_DIG = CNT_W'(DIGIT_COUNT - 1);
   localparam logic [QCNT_W-1:0] Q_FULL  = QCNT_W'(QUEUE_DEPTH);

   // classify stage: holds one transaction while its table index is formed
   logic               hold_valid_ff, hold_valid_in;
   logic               hold_done_ff, hold_done_in;
   item_type           hold_item_ff, hold_item_in;
   logic [IDX_W-1:0]   hold_rem_ff, hold_rem_in;
   logic [ADDR_W-1:0]  hold_sh_ff, hold_sh_in;
   logic [CNT_W-1:0]   hold_cnt_ff, hold_cnt_in;
   logic [IDX_W-1:0]   rem_step;
   logic               accept;
   logic               push;
   logic               q_full;

   // queue toward the back end
   item_type           q_item_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0]   q_idx_ff  [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  q_cnt_ff, q_cnt_in;

   // handshake
   assign q_full    = (q_cnt_ff == Q_FULL);
   assign push      = hold_valid_ff && hold_done_ff && !q_full;
   assign req_stall = clearing || (hold_valid_ff && !push);
   assign accept    = req_valid && !req_stall;

   // remainder step: DIGIT_BITS address bits folded in, modulo table size
   always_comb begin
      logic [IDX_W:0] r;
      r = {1'b0, hold_rem_ff};
      for (int k = 0; k < DIGIT_BITS; k++) begin
         r = {r[IDX_W-1:0], hold_sh_ff[ADDR_W-1-k]};
         if (r >= MODULUS) begin
            r = r - MODULUS;
         end
      end
      rem_step = r[IDX_W-1:0];
   end

   // classify stage next values
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_done_in  = hold_done_ff;
      hold_item_in  = hold_item_ff;
      hold_rem_in   = hold_rem_ff;
      hold_sh_in    = hold_sh_ff;
      hold_cnt_in   = hold_cnt_ff;
      if (accept) begin
         hold_valid_in     = 1'b1;
         hold_item_in.pc   = req_access_pc;
         hold_item_in.addr = req_access_address;
         hold_sh_in        = req_access_pc;
         hold_cnt_in       = '0;
         if (IS_POW2) begin
            hold_rem_in  = req_access_pc[IDX_W-1:0];
            hold_done_in = 1'b1;
         end else begin
            hold_rem_in  = '0;
            hold_done_in = 1'b0;
         end
      end else if (push) begin
         hold_valid_in = 1'b0;
      end else if (hold_valid_ff && !hold_done_ff) begin
         hold_rem_in  = rem_step;
         hold_sh_in   = hold_sh_ff << DIGIT_BITS;
         hold_cnt_in  = hold_cnt_ff + 1'b1;
         hold_done_in = (hold_cnt_ff == LAST_DIG);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         hold_done_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         hold_done_ff  <= hold_done_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_item_ff <= hold_item_in;
      hold_rem_ff  <= hold_rem_in;
      hold_sh_ff   <= hold_sh_in;
      hold_cnt_ff  <= hold_cnt_in;
   end

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      q_cnt_in  = q_cnt_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         q_cnt_in = q_cnt_ff + 1'b1;
      end else if (!push && q_pop) begin
         q_cnt_in = q_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         q_cnt_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         q_cnt_ff  <= q_cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_item_ff[wr_ptr_ff] <= hold_item_ff;
         q_idx_ff[wr_ptr_ff]  <= hold_rem_ff;
      end
   end

   assign q_valid = (q_cnt_ff != '0);
   assign q_item  = q_item_ff[rd_ptr_ff];
   assign q_idx   = q_idx_ff[rd_ptr_ff];

endmodule

@@ design/spt_back.sv @@
module spt_back import spt_pkg::*; #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [ADDR_W-1:0]                max_phys_addr,
   input  logic                             q_valid,
   input  item_type                         q_item,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] q_idx,
   output logic                             q_pop,
   output logic                             clearing,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_table_hit,
   output logic                             rsp_prefetch_valid,
   output logic [ADDR_W-1:0]                rsp_prefetch_target
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   back_state_type      state_ff, state_in;
   logic [IDX_W-1:0]    clr_cnt_ff, clr_cnt_in;

   // transaction under work
   item_type            cur_item_ff;
   logic [IDX_W-1:0]    cur_idx_ff;
   logic                hit_ff;
   logic [STRIDE_W-1:0] stride_ff;
   conf_type            conf_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff;
   logic                rsp_pf_valid_ff;
   logic [ADDR_W-1:0]   rsp_target_ff;

   // table port
   logic                ram_we;
   logic                ram_re;
   logic [IDX_W-1:0]    ram_wr_addr;
   entry_type           ram_wr_data;
   logic [$bits(entry_type)-1:0] ram_rd_data;
   entry_type           rd_entry;

   // lookup and resolve datapath
   logic                look_hit;
   logic                look_ok;
   logic [ADDR_W-1:0]   look_pred;
   logic [STRIDE_W-1:0] look_delta;
   logic [STRIDE_W-1:0] look_stride;
   conf_type            look_conf;
   entry_type           upd_entry;
   logic [ADDR_W-1:0]   res_target;
   logic                res_pf_valid;
   logic                out_free;
   logic                out_load;

   spt_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_re),
      .rd_addr (q_idx),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = entry_type'(ram_rd_data);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR: begin
            if (clr_cnt_ff == LAST_IDX) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (q_valid) begin
               state_in = BK_LOOKUP;
            end
         end
         BK_LOOKUP: begin
            state_in = BK_RESOLVE;
         end
         BK_RESOLVE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_CLEAR;
      endcase
   end

   // sequencer outputs
   always_comb begin
      clearing = 1'b0;
      q_pop    = 1'b0;
      ram_we   = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         BK_CLEAR: begin
            clearing = 1'b1;
            ram_we   = 1'b1;
         end
         BK_IDLE: begin
            q_pop = q_valid;
         end
         BK_LOOKUP: begin
            ram_we = 1'b1;
         end
         BK_RESOLVE: begin
            out_load = out_free;
         end
         default: clearing = 1'b0;
      endcase
   end

   assign ram_re = q_pop;

   // clearing sweep counter
   assign clr_cnt_in = clr_cnt_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_CLEAR) begin
            clr_cnt_ff <= clr_cnt_in;
         end
      end
   end

   // lookup: tag match, prediction check, new stride and confidence
   assign look_hit   = (rd_entry.tag == cur_item_ff.pc);
   assign look_pred  = rd_entry.last_addr + sext_stride(rd_entry.stride);
   assign look_ok    = (cur_item_ff.addr == look_pred);
   assign look_delta = cur_item_ff.addr[STRIDE_W-1:0] - rd_entry.last_addr[STRIDE_W-1:0];
   assign look_conf  = look_hit ? next_conf(rd_entry.conf, look_ok) : CONF_INIT;

   always_comb begin
      look_stride = '0;
      if (look_hit) begin
         if (rd_entry.conf != CONF_STEADY || look_ok) begin
            look_stride = look_delta;
         end else begin
            look_stride = rd_entry.stride;
         end
      end
   end

   assign upd_entry.tag       = cur_item_ff.pc;
   assign upd_entry.last_addr = cur_item_ff.addr;
   assign upd_entry.stride    = look_stride;
   assign upd_entry.conf      = look_conf;

   assign ram_wr_addr = clearing ? clr_cnt_ff : cur_idx_ff;
   assign ram_wr_data = clearing ? entry_type'('0) : upd_entry;

   // work registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_item_ff <= q_item;
         cur_idx_ff  <= q_idx;
      end
      if (state_ff == BK_LOOKUP) begin
         hit_ff    <= look_hit;
         stride_ff <= look_stride;
         conf_ff   <= look_conf;
      end
   end

   // resolve: prefetch target and range check
   assign res_target   = cur_item_ff.addr + sext_stride(stride_ff);
   assign res_pf_valid = hit_ff && (conf_ff != CONF_NOPRED) && (res_target <= max_phys_addr);

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_hit_ff      <= hit_ff;
         rsp_pf_valid_ff <= res_pf_valid;
         rsp_target_ff   <= res_target;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_table_hit       = rsp_hit_ff;
   assign rsp_prefetch_valid  = rsp_pf_valid_ff;
   assign rsp_prefetch_target = rsp_target_ff;

`ifndef SYNTHESIS
   // no transaction leaves the queue while the table is being cleared
   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !q_pop)
      else $error("queue popped during table clear");

   // a popped transaction is looked up in the very next cycle
   a_pop_then_lookup: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == BK_LOOKUP)
      else $error("pop not followed by lookup");

   // a prefetch is only raised on a table hit
   a_pf_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_prefetch_valid || rsp_table_hit))
      else $error("prefetch without table hit");

   // a waiting result is never overwritten by a new one
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !out_load)
      else $error("result register overwritten while stalled");
`endif

endmodule

@@ design/stride_prefetch_table_unit.sv @@
// stride prefetch table: one memory access in, one prediction result out
//
// request channel (req_valid / req_stall): instruction address and data
// address of one load or store. a transaction is taken when req_valid is
// high and req_stall is low.
// response channel (rsp_valid / rsp_stall): table hit, prefetch valid and
// prefetch target. the result stays on the ports while rsp_stall is high;
// meanwhile requests are taken until the back end, the queue and the
// classify stage are all full; then req_stall rises.
// csr channel (csr_valid / csr_ready): writes the highest address a
// prefetch may target; resets to 0xFFFFFFFF. csr_ready is always high.
//
// a request passes the front end's classify stage and queue, then the back
// end's read, update and resolve steps on the one table port; the back end
// takes no new transaction until the last one is resolved. for table sizes
// that are not a power of two the front end forms the index 4 address bits
// per cycle and takes no new request until the index is formed and queued.
// after reset the table is swept to zero, one entry per cycle, over all
// TABLE_ENTRIES entries; req_stall is high during the sweep.
module stride_prefetch_table_unit import spt_pkg::*; #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [ADDR_W-1:0] req_access_pc,
   input  logic [ADDR_W-1:0] req_access_address,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_table_hit,
   output logic              rsp_prefetch_valid,
   output logic [ADDR_W-1:0] rsp_prefetch_target,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [ADDR_W-1:0] csr_max_phys_addr
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [ADDR_W-1:0] MAX_ADDR_RESET = 64'h0000_0000_FFFF_FFFF;

   logic [ADDR_W-1:0] max_addr_ff, max_addr_in;
   logic              q_valid;
   item_type          q_item;
   logic [IDX_W-1:0]  q_idx;
   logic              q_pop;
   logic              clearing;

   // limit register
   assign csr_ready   = 1'b1;
   assign max_addr_in = (csr_valid && csr_ready) ? csr_max_phys_addr : max_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_addr_ff <= MAX_ADDR_RESET;
      end else begin
         max_addr_ff <= max_addr_in;
      end
   end

   // request side: index forming and queue
   spt_front #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_access_pc      (req_access_pc),
      .req_access_address (req_access_address),
      .clearing           (clearing),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_idx              (q_idx),
      .q_pop              (q_pop)
   );

   // table update and response side
   spt_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .max_phys_addr       (max_addr_ff),
      .q_valid             (q_valid),
      .q_item              (q_item),
      .q_idx               (q_idx),
      .q_pop               (q_pop),
      .clearing            (clearing),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_table_hit       (rsp_table_hit),
      .rsp_prefetch_valid  (rsp_prefetch_valid),
      .rsp_prefetch_target (rsp_prefetch_target)
   );

endmodule
